/* design/lebuf_pkg.sv */
package lebuf_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   // Fixed widths of the request and response fields.
   localparam int CMD_W   = 2;
   localparam int CODE_W  = 3;
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_KEY    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SETCUR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

   // Special key codes.
   localparam logic [CODE_W-1:0] KEY_BACKSPACE = 3'd0;
   localparam logic [CODE_W-1:0] KEY_DELETE    = 3'd1;
   localparam logic [CODE_W-1:0] KEY_LEFT      = 3'd2;
   localparam logic [CODE_W-1:0] KEY_RIGHT     = 3'd3;
   localparam logic [CODE_W-1:0] KEY_HOME      = 3'd4;
   localparam logic [CODE_W-1:0] KEY_END       = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request fields
      logic ptr_init;  // set the shift pointer for an insert or a removal
      logic mem_rd;    // read the character store
      logic mem_wr;    // write the character just read, one place along
      logic ptr_step;  // advance the shift pointer
      logic commit;    // update length, cursor and flag, and issue the response
   } lebuf_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic is_read;
      logic shift_more;
   } lebuf_sts_type;

endpackage

/* design/lebuf_ctrl.sv */
module lebuf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  lebuf_pkg::lebuf_sts_type sts,
   output lebuf_pkg::lebuf_ctl_type ctl
);
   import lebuf_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_SHIFT_RD = 3'd2;
   localparam logic [2:0] S_SHIFT_WR = 3'd3;
   localparam logic [2:0] S_FINISH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_insert || sts.is_remove) begin
               ctl.ptr_init = 1'b1;
               state_in     = S_SHIFT_RD;
            end else begin
               // A read in range fetches its character now; the data is
               // registered by the time the result is formed.
               ctl.mem_rd = sts.is_read;
               state_in   = S_FINISH;
            end
         end
         S_SHIFT_RD: begin
            if (sts.shift_more) begin
               ctl.mem_rd = 1'b1;
               state_in   = S_SHIFT_WR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            ctl.mem_wr   = 1'b1;
            ctl.ptr_step = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            ctl.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/lebuf_datapath.sv */
module lebuf_datapath #(
   parameter int CAPACITY = lebuf_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lebuf_pkg::lebuf_ctl_type           ctl,
   output lebuf_pkg::lebuf_sts_type           sts,
   input  logic [lebuf_pkg::CMD_W-1:0]        req_cmd,
   input  logic                               req_is_press,
   input  logic                               req_is_printable,
   input  logic [lebuf_pkg::CODE_W-1:0]       req_key_code,
   input  logic [lebuf_pkg::CHAR_W-1:0]       req_char_in,
   input  logic [lebuf_pkg::POS_W-1:0]        req_position,
   output logic                               rsp_strobe,
   output logic                               rsp_handled,
   output logic [lebuf_pkg::COUNT_W-1:0]      rsp_length,
   output logic [lebuf_pkg::COUNT_W-1:0]      rsp_cursor,
   output logic                               rsp_composing,
   output logic                               rsp_full_res,
   output logic [lebuf_pkg::CHAR_W-1:0]       rsp_char_out
);
   import lebuf_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   // Captured request.
   logic [CMD_W-1:0]  cmd_ff;
   logic              press_ff;
   logic              printable_ff;
   logic [CODE_W-1:0] code_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [POS_W-1:0]  pos_ff;

   // Architectural state.
   logic [LEN_W-1:0]  len_ff,  len_in;
   logic [LEN_W-1:0]  cur_ff,  cur_in;
   logic              comp_ff, comp_in;

   logic [LEN_W-1:0]  ptr_ff;
   logic [CHAR_W-1:0] text_store_ff [CAPACITY];
   logic [CHAR_W-1:0] rd_data_ff;

   logic              rsp_strobe_ff;
   logic              handled_ff, handled_in;
   logic              full_ff,    full_in;
   logic [COUNT_W-1:0] length_ff;
   logic [COUNT_W-1:0] cursor_ff;
   logic              composing_ff;
   logic [CHAR_W-1:0] char_out_ff, char_out_in;

   logic              key_press;
   logic              ins_req;
   logic              ins_ok;
   logic              bs_ok;
   logic              del_ok;
   logic              rd_ok;
   logic              setcur_ok;
   logic              cur_nonzero;
   logic              cur_below_len;
   logic [CMP_W-1:0]  pos_cmp;
   logic [CMP_W-1:0]  len_cmp;
   logic [LEN_W-1:0]  ptr_next;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              mem_we;

   always_comb begin
      key_press     = (cmd_ff == CMD_KEY) && press_ff;
      ins_req       = key_press && printable_ff;
      ins_ok        = ins_req && (len_ff < CAP_LEN);
      cur_nonzero   = (cur_ff != '0);
      cur_below_len = (cur_ff < len_ff);
      bs_ok         = key_press && !printable_ff && (code_ff == KEY_BACKSPACE) && cur_nonzero;
      del_ok        = key_press && !printable_ff && (code_ff == KEY_DELETE) && cur_below_len;
      pos_cmp       = CMP_W'(pos_ff);
      len_cmp       = CMP_W'(len_ff);
      rd_ok         = (cmd_ff == CMD_READ) && (pos_cmp < len_cmp);
      setcur_ok     = (cmd_ff == CMD_SETCUR) && (pos_cmp <= len_cmp);
   end

   always_comb begin
      sts.is_insert = ins_ok;
      sts.is_remove = bs_ok || del_ok;
      sts.is_read   = rd_ok;
      if (ins_ok) begin
         sts.shift_more = (ptr_ff > cur_ff);
      end else begin
         sts.shift_more = ((ptr_ff + LEN_W'(1)) < len_ff);
      end
   end

   // Insert moves characters up from the top end; removal moves them down.
   assign ptr_next = ins_ok ? (ptr_ff - LEN_W'(1)) : (ptr_ff + LEN_W'(1));

   always_comb begin
      if (rd_ok) begin
         rd_addr = IDX_W'(pos_ff);
      end else begin
         rd_addr = ptr_next[IDX_W-1:0];
      end
      if (ctl.commit) begin
         wr_addr = cur_ff[IDX_W-1:0];
         wr_data = char_ff;
      end else begin
         wr_addr = ptr_ff[IDX_W-1:0];
         wr_data = rd_data_ff;
      end
      mem_we = ctl.mem_wr || (ctl.commit && ins_ok);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_store_ff[wr_addr] <= wr_data;
      end
      if (ctl.mem_rd) begin
         rd_data_ff <= text_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff       <= req_cmd;
         press_ff     <= req_is_press;
         printable_ff <= req_is_printable;
         code_ff      <= req_key_code;
         char_ff      <= req_char_in;
         pos_ff       <= req_position;
      end
      if (ctl.ptr_init) begin
         if (ins_ok) begin
            ptr_ff <= len_ff;
         end else if (bs_ok) begin
            ptr_ff <= cur_ff - LEN_W'(1);
         end else begin
            ptr_ff <= cur_ff;
         end
      end else if (ctl.ptr_step) begin
         ptr_ff <= ptr_next;
      end
   end

   // Outcome of the command, applied when the controller commits.
   always_comb begin
      len_in      = len_ff;
      cur_in      = cur_ff;
      comp_in     = comp_ff;
      handled_in  = 1'b0;
      full_in     = 1'b0;
      char_out_in = '0;
      case (cmd_ff)
         CMD_KEY: begin
            if (press_ff && printable_ff) begin
               if (ins_ok) begin
                  len_in     = len_ff + LEN_W'(1);
                  cur_in     = cur_ff + LEN_W'(1);
                  comp_in    = 1'b1;
                  handled_in = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end else if (press_ff) begin
               case (code_ff)
                  KEY_BACKSPACE: begin
                     if (cur_nonzero) begin
                        len_in     = len_ff - LEN_W'(1);
                        cur_in     = cur_ff - LEN_W'(1);
                        handled_in = 1'b1;
                     end
                  end
                  KEY_DELETE: begin
                     if (cur_below_len) begin
                        len_in     = len_ff - LEN_W'(1);
                        handled_in = 1'b1;
                     end
                  end
                  KEY_LEFT: begin
                     if (cur_nonzero) begin
                        cur_in     = cur_ff - LEN_W'(1);
                        handled_in = 1'b1;
                     end
                  end
                  KEY_RIGHT: begin
                     if (cur_below_len) begin
                        cur_in     = cur_ff + LEN_W'(1);
                        handled_in = 1'b1;
                     end
                  end
                  KEY_HOME: begin
                     if (cur_nonzero) begin
                        cur_in     = '0;
                        handled_in = 1'b1;
                     end
                  end
                  KEY_END: begin
                     if (cur_below_len) begin
                        cur_in     = len_ff;
                        handled_in = 1'b1;
                     end
                  end
                  default: begin
                     handled_in = 1'b0;
                  end
               endcase
            end
         end
         CMD_CLEAR: begin
            len_in     = '0;
            cur_in     = '0;
            comp_in    = 1'b0;
            handled_in = 1'b1;
         end
         CMD_SETCUR: begin
            if (setcur_ok) begin
               cur_in     = LEN_W'(pos_ff);
               handled_in = 1'b1;
            end
         end
         default: begin
            if (rd_ok) begin
               char_out_in = rd_data_ff;
               handled_in  = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         cur_ff        <= '0;
         comp_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.commit;
         if (ctl.commit) begin
            len_ff  <= len_in;
            cur_ff  <= cur_in;
            comp_ff <= comp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         handled_ff   <= handled_in;
         full_ff      <= full_in;
         length_ff    <= COUNT_W'(len_in);
         cursor_ff    <= COUNT_W'(cur_in);
         composing_ff <= comp_in;
         char_out_ff  <= char_out_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_handled   = handled_ff;
   assign rsp_length    = length_ff;
   assign rsp_cursor    = cursor_ff;
   assign rsp_composing = composing_ff;
   assign rsp_full_res  = full_ff;
   assign rsp_char_out  = char_out_ff;

endmodule

/* design/line_edit_buffer_core.sv */
// The request is taken at the accepting edge and a decide state follows; an insert, backspace
// or delete that is carried out then loops over a read state and a write state for each
// character moved (length - cursor for an insert, the characters above the removed one for a
// removal); a finish state commits, and the result beat is registered from it.
// The next command is taken at the edge that takes the result beat; commands do not overlap.
// Reset (synchronous): length, cursor and flag clear; store kept. The receiver cannot stall.
module line_edit_buffer_core #(
   parameter int CAPACITY = lebuf_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lebuf_pkg::CMD_W-1:0]   req_cmd,
   input  logic                          req_is_press,
   input  logic                          req_is_printable,
   input  logic [lebuf_pkg::CODE_W-1:0]  req_key_code,
   input  logic [lebuf_pkg::CHAR_W-1:0]  req_char_in,
   input  logic [lebuf_pkg::POS_W-1:0]   req_position,
   output logic                          rsp_strobe,
   output logic                          rsp_handled,
   output logic [lebuf_pkg::COUNT_W-1:0] rsp_length,
   output logic [lebuf_pkg::COUNT_W-1:0] rsp_cursor,
   output logic                          rsp_composing,
   output logic                          rsp_full_res,
   output logic [lebuf_pkg::CHAR_W-1:0]  rsp_char_out
);
   import lebuf_pkg::*;

   // The controller sequences each command: it captures the request beat, lets the
   // datapath decide what the command needs, steps the shift loop through the store
   // when characters must move, and finally commits the new length, cursor and flag.
   // The result beat appears on the cycle after the commit, for one cycle only.
   lebuf_ctl_type ctl;
   lebuf_sts_type sts;

   lebuf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   // The datapath holds the character store, the pointer used while shifting, the
   // length, cursor and composing flag, and the registered result fields.
   lebuf_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_is_press     (req_is_press),
      .req_is_printable (req_is_printable),
      .req_key_code     (req_key_code),
      .req_char_in      (req_char_in),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_handled      (rsp_handled),
      .rsp_length       (rsp_length),
      .rsp_cursor       (rsp_cursor),
      .rsp_composing    (rsp_composing),
      .rsp_full_res     (rsp_full_res),
      .rsp_char_out     (rsp_char_out)
   );

endmodule
